// ===== hw/rtl/accp_pkg.sv =====
// Shared types and constants of the ASCII CAN command parser.
// No dependencies; imported by every module of the block.
package accp_pkg;

  // Widest line count over the supported line lengths (up to 256 chars).
  localparam int unsigned JOB_CNT_W = 9;
  localparam int unsigned ADDR_W    = 8;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [2:0] {
    KIND_PONG    = 3'd0,
    KIND_STATUS  = 3'd1,
    KIND_RECOVER = 3'd2,
    KIND_FRAME   = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_UNKNOWN  = 3'd0,
    ERR_USAGE    = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_BYTE     = 3'd3,
    ERR_TOO_LONG = 3'd4
  } err_e;

  // Work handed from the front to the back.
  typedef struct packed {
    logic                 too_long;
    logic [JOB_CNT_W-1:0] count;
  } job_t;

  // Line store write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

// ===== hw/rtl/accp_jobq.sv =====
// Two-entry job queue between the front and the back.
// Depends on accp_pkg (job_t).
module accp_jobq
  import accp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        slot_q[wp_q] <= job_i;
        wp_q         <= ~wp_q;
      end
      if (pop_i && valid_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && valid_o) ? 1 : 0);
    end
  end

endmodule

// ===== hw/rtl/accp_front.sv =====
// Front end: takes characters, fills the line store, queues decode jobs.
// Depends on accp_pkg (job_t, wr_t, character codes).
module accp_front
  import accp_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_in_i,
  input  logic       push_i,
  output logic       full_o,
  output wr_t        wr_o,
  output logic       job_push_o,
  output job_t       job_o,
  input  logic       jq_full_i,
  input  logic       release_i
);

  localparam int unsigned CW = $clog2(LINE_MAX + 1);

  logic [CW-1:0] count_q, count_d;
  logic          lock_q, lock_d;
  logic          acc;

  // lock: a decode job owns the line store until the back releases it
  assign full_o = lock_q | jq_full_i;
  assign acc    = push_i & ~full_o;

  always_comb begin
    count_d    = count_q;
    lock_d     = lock_q & ~release_i;
    wr_o       = '0;
    job_push_o = 1'b0;
    job_o      = '0;
    if (acc && char_in_i != CHAR_CR) begin
      if (char_in_i == CHAR_LF) begin
        job_push_o     = 1'b1;
        job_o.too_long = 1'b0;
        job_o.count    = JOB_CNT_W'(count_q);
        count_d        = '0;
        lock_d         = 1'b1;
      end else if (count_q == CW'(LINE_MAX)) begin
        job_push_o     = 1'b1;
        job_o.too_long = 1'b1;
        count_d        = '0;
      end else begin
        wr_o.en   = 1'b1;
        wr_o.addr = ADDR_W'(count_q);
        wr_o.data = char_in_i;
        count_d   = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lock_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      lock_q  <= lock_d;
    end
  end

endmodule

// ===== hw/rtl/accp_back.sv =====
// Back end: line store, two-pass line decoder and result register.
// Depends on accp_pkg (job_t, wr_t, kind_e, err_e, character codes).
module accp_back
  import accp_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wr_t         wr_i,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        release_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  kind_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] frame_id_o,
  output logic        extended_o,
  output logic [3:0]  length_o,
  output logic [63:0] payload_o
);

  localparam int unsigned IW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int unsigned CW = $clog2(LINE_MAX + 1);

  localparam logic [55:0] S_PING    = 56'("PING");
  localparam logic [55:0] S_STATUS  = 56'("STATUS");
  localparam logic [55:0] S_RECOVER = 56'("RECOVER");
  localparam logic [55:0] S_TX      = 56'("TX");
  localparam logic [55:0] S_TXE     = 56'("TXE");

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_PARSE, B_EMIT} bst_e;
  typedef enum logic [2:0] {ID_FIRST, ID_ZERO, ID_X, ID_DIG, ID_STOP} idst_e;

  function automatic logic [7:0] str_byte(input logic [55:0] s, input int n, input int k);
    logic [7:0] b;
    b = 8'h00;
    for (int i = 0; i < 7; i++) begin
      if (i == k && i < n) b = s[8*(n-1-i) +: 8];
    end
    return b;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);  // {ok, digit}
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  logic [7:0] mem [LINE_MAX];
  logic [7:0] rd_q;
  logic       rd_en;

  bst_e          st_q, st_d;
  logic [CW-1:0] ra_q, ra_d, hi_q, hi_d, ridx_q, s_q, s_d, e_q, e_d;
  logic          rv_q, err_job_q, err_job_d, found_q, found_d;
  // whole-line and first-token matches
  logic          m_ping_q, m_ping_d, m_stat_q, m_stat_d, m_rec_q, m_rec_d;
  logic          m_tx_q, m_tx_d, m_txe_q, m_txe_d, is_tx_q, is_tx_d, is_txe_q, is_txe_d;
  // tokenizer
  logic          in_tok_q, in_tok_d;
  logic [3:0]    j_q, j_d, t_q, t_d;
  // identifier, length and data bytes
  idst_e         id_st_q, id_st_d;
  logic [31:0]   id_v_q, id_v_d;
  logic          id_sat_q, id_sat_d, id_neg_q, id_neg_d, id_have_q, id_have_d;
  logic [7:0]    len_v_q, len_v_d, len_q, len_d;
  logic          len_neg_q, len_neg_d, len_stop_q, len_stop_d, len_have_q, len_have_d;
  logic [3:0]    b_hi_q, b_hi_d, b_lo_q, b_lo_d, bi_q, bi_d;
  logic          b_ok_q, b_ok_d, bad_q, bad_d;
  logic [63:0]   data_q, data_d;
  // result register
  logic          ov_q, ov_d;
  logic [2:0]    kind_q, kind_d, err_q, err_d;
  logic [31:0]   fid_q, fid_d;
  logic          ext_q, ext_d;
  logic [3:0]    flen_q, flen_d;
  logic [63:0]   pay_q, pay_d;

  assign rd_en = (st_q == B_SCAN || st_q == B_PARSE) && (ra_q != hi_q);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr[IW-1:0]] <= wr_i.data;
    if (rd_en) rd_q <= mem[ra_q[IW-1:0]];
  end

  always_comb begin
    logic [7:0]    c;
    logic [CW-1:0] k, span;
    logic          last, in_char, end_sp, end_tok, hv;
    logic [3:0]    d, j, jn, tok_len;
    logic [4:0]    hx;
    idst_e         ist;

    c       = rd_q;
    k       = ridx_q - s_q;
    span    = e_q - s_q;
    last    = (ridx_q + CW'(1)) == e_q;
    hx      = hex_val(c);
    hv      = hx[4];
    d       = hx[3:0];
    in_char = in_tok_q ? (c != CHAR_SPACE) : !is_ws(c);
    end_sp  = in_tok_q && (c == CHAR_SPACE);
    end_tok = end_sp || (in_char && last);
    j       = in_tok_q ? j_q : 4'd0;
    jn      = (j == 4'd15) ? j : j + 4'd1;
    tok_len = end_sp ? j_q : jn;
    ist     = (j == 4'd0) ? ID_FIRST : id_st_q;

    st_d = st_q;  ra_d = ra_q;  hi_d = hi_q;  s_d = s_q;  e_d = e_q;
    err_job_d = err_job_q;  found_d = found_q;
    m_ping_d = m_ping_q;  m_stat_d = m_stat_q;  m_rec_d = m_rec_q;
    m_tx_d = m_tx_q;  m_txe_d = m_txe_q;  is_tx_d = is_tx_q;  is_txe_d = is_txe_q;
    in_tok_d = in_tok_q;  j_d = j_q;  t_d = t_q;
    id_st_d = id_st_q;  id_v_d = id_v_q;  id_sat_d = id_sat_q;
    id_neg_d = id_neg_q;  id_have_d = id_have_q;
    len_v_d = len_v_q;
    len_d = len_q;  len_neg_d = len_neg_q;  len_stop_d = len_stop_q;  len_have_d = len_have_q;
    b_hi_d = b_hi_q;  b_lo_d = b_lo_q;  bi_d = bi_q;  b_ok_d = b_ok_q;  bad_d = bad_q;
    data_d = data_q;
    ov_d = ov_q & ~pop_i;
    kind_d = kind_q;  err_d = err_q;  fid_d = fid_q;  ext_d = ext_q;
    flen_d = flen_q;  pay_d = pay_q;
    job_pop_o = 1'b0;
    release_o = 1'b0;

    if (rd_en) ra_d = ra_q + CW'(1);

    unique case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          err_job_d = job_i.too_long;
          ra_d      = '0;
          hi_d      = CW'(job_i.count);
          found_d   = 1'b0;
          st_d      = job_i.too_long ? B_EMIT : B_SCAN;
        end
      end
      B_SCAN: begin
        // trim pass: first and one past last non-blank character
        if (rv_q && !is_ws(c)) begin
          if (!found_q) s_d = ridx_q;
          found_d = 1'b1;
          e_d     = ridx_q + CW'(1);
        end
        if (ra_q == hi_q && !rv_q) begin
          if (found_q) begin
            ra_d = s_q;  hi_d = e_q;
            m_ping_d = 1'b1;  m_stat_d = 1'b1;  m_rec_d = 1'b1;
            m_tx_d = 1'b1;  m_txe_d = 1'b1;  is_tx_d = 1'b0;  is_txe_d = 1'b0;
            in_tok_d = 1'b0;  j_d = '0;  t_d = '0;
            id_st_d = ID_FIRST;  id_v_d = '0;  id_sat_d = 1'b0;
            id_neg_d = 1'b0;  id_have_d = 1'b0;
            len_v_d = '0;  len_d = '0;  len_neg_d = 1'b0;
            len_stop_d = 1'b0;  len_have_d = 1'b0;
            bi_d = '0;  bad_d = 1'b0;  data_d = '0;  b_ok_d = 1'b0;
            st_d = B_PARSE;
          end else begin
            release_o = 1'b1;
            st_d      = B_IDLE;
          end
        end
      end
      B_PARSE: begin
        if (rv_q) begin
          m_ping_d = m_ping_q && (k < CW'(4)) && (c == str_byte(S_PING, 4, int'(k)));
          m_stat_d = m_stat_q && (k < CW'(6)) && (c == str_byte(S_STATUS, 6, int'(k)));
          m_rec_d  = m_rec_q && (k < CW'(7)) && (c == str_byte(S_RECOVER, 7, int'(k)));
          if (in_char) begin
            in_tok_d = 1'b1;
            j_d      = jn;
            if (t_q == 4'd0) begin
              m_tx_d  = m_tx_q && (j < 4'd2) && (c == str_byte(S_TX, 2, int'(j)));
              m_txe_d = m_txe_q && (j < 4'd3) && (c == str_byte(S_TXE, 3, int'(j)));
            end else if (t_q == 4'd1) begin
              if (j == 4'd0 && (c == "+" || c == "-")) begin
                id_neg_d = (c == "-");
                id_st_d  = ID_FIRST;
              end else begin
                id_st_d = ID_STOP;
                unique case (ist)
                  ID_FIRST: id_st_d = (c == "0") ? ID_ZERO : (hv ? ID_DIG : ID_STOP);
                  ID_ZERO:  id_st_d = (c == "x" || c == "X") ? ID_X :
                                      (hv ? ID_DIG : ID_STOP);
                  ID_X, ID_DIG: id_st_d = hv ? ID_DIG : ID_STOP;
                  ID_STOP:  id_st_d = ID_STOP;
                  default:  id_st_d = ID_STOP;
                endcase
                // shift in a digit; an overflow past 32 bits saturates
                if (id_st_d == ID_DIG && !id_sat_q) begin
                  if (id_v_q[31:28] != 4'd0) id_sat_d = 1'b1;
                  id_v_d = {id_v_q[27:0], d};
                end
              end
            end else if (t_q == 4'd2) begin
              if (j == 4'd0 && (c == "+" || c == "-")) begin
                len_neg_d = (c == "-");
              end else if (!len_stop_q) begin
                if (c >= "0" && c <= "9") begin
                  len_v_d = (len_v_q << 3) + (len_v_q << 1) + {4'd0, d};
                end else begin
                  len_stop_d = 1'b1;
                end
              end
            end else if (j == 4'd0) begin
              b_hi_d = d;
              b_ok_d = hv;
            end else if (j == 4'd1) begin
              b_lo_d = d;
              b_ok_d = b_ok_q & hv;
            end
          end else if (end_sp) begin
            in_tok_d = 1'b0;
            j_d      = '0;
          end
          if (end_tok) begin
            t_d = (t_q == 4'd15) ? t_q : t_q + 4'd1;
            if (t_q == 4'd0) begin
              is_tx_d  = m_tx_d && (tok_len == 4'd2);
              is_txe_d = m_txe_d && (tok_len == 4'd3);
            end else if (t_q == 4'd1) begin
              id_have_d = 1'b1;
            end else if (t_q == 4'd2) begin
              len_have_d = 1'b1;
              len_d      = len_neg_d ? 8'd0 - len_v_d : len_v_d;
            end else begin
              bi_d = (bi_q == 4'd15) ? bi_q : bi_q + 4'd1;
              if ({4'd0, bi_q} < len_q) begin
                if (tok_len == 4'd2 && b_ok_d && !bi_q[3]) begin
                  data_d[{bi_q[2:0], 3'b000} +: 8] = {b_hi_d, b_lo_d};
                end else begin
                  bad_d = 1'b1;
                end
              end
            end
          end
        end
        if (ra_q == hi_q && !rv_q) begin
          release_o = 1'b1;
          st_d      = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!ov_q) begin
          ov_d   = 1'b1;
          kind_d = KIND_ERROR;
          err_d  = 3'(ERR_UNKNOWN);
          fid_d  = '0;
          ext_d  = 1'b0;
          flen_d = '0;
          pay_d  = '0;
          priority if (err_job_q) begin
            err_d = ERR_TOO_LONG;
          end else if (span == CW'(4) && m_ping_q) begin
            kind_d = KIND_PONG;
            err_d  = '0;
          end else if (span == CW'(6) && m_stat_q) begin
            kind_d = KIND_STATUS;
            err_d  = '0;
          end else if (span == CW'(7) && m_rec_q) begin
            kind_d = KIND_RECOVER;
            err_d  = '0;
          end else if (!(is_tx_q || is_txe_q)) begin
            err_d = ERR_UNKNOWN;
          end else if (!(id_have_q && len_have_q)) begin
            err_d = ERR_USAGE;
          end else if (len_q > 8'd8) begin
            err_d = ERR_LENGTH;
          end else if (bad_q || ({4'd0, bi_q} < len_q)) begin
            err_d = ERR_BYTE;
          end else begin
            kind_d = KIND_FRAME;
            err_d  = '0;
            fid_d  = id_sat_q ? 32'hFFFF_FFFF : (id_neg_q ? 32'd0 - id_v_q : id_v_q);
            ext_d  = is_txe_q;
            flen_d = len_q[3:0];
            pay_d  = data_q;
          end
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;  ra_q <= '0;  hi_q <= '0;  ridx_q <= '0;  rv_q <= 1'b0;
      s_q <= '0;  e_q <= '0;  err_job_q <= 1'b0;  found_q <= 1'b0;
      m_ping_q <= 1'b0;  m_stat_q <= 1'b0;  m_rec_q <= 1'b0;
      m_tx_q <= 1'b0;  m_txe_q <= 1'b0;  is_tx_q <= 1'b0;  is_txe_q <= 1'b0;
      in_tok_q <= 1'b0;  j_q <= '0;  t_q <= '0;
      id_st_q <= ID_FIRST;  id_v_q <= '0;  id_sat_q <= 1'b0;
      id_neg_q <= 1'b0;  id_have_q <= 1'b0;
      len_v_q <= '0;  len_q <= '0;  len_neg_q <= 1'b0;
      len_stop_q <= 1'b0;  len_have_q <= 1'b0;
      b_hi_q <= '0;  b_lo_q <= '0;  bi_q <= '0;  b_ok_q <= 1'b0;  bad_q <= 1'b0;
      data_q <= '0;
      ov_q <= 1'b0;  kind_q <= '0;  err_q <= '0;  fid_q <= '0;
      ext_q <= 1'b0;  flen_q <= '0;  pay_q <= '0;
    end else begin
      st_q <= st_d;  ra_q <= ra_d;  hi_q <= hi_d;  ridx_q <= ra_q;  rv_q <= rd_en;
      s_q <= s_d;  e_q <= e_d;  err_job_q <= err_job_d;  found_q <= found_d;
      m_ping_q <= m_ping_d;  m_stat_q <= m_stat_d;  m_rec_q <= m_rec_d;
      m_tx_q <= m_tx_d;  m_txe_q <= m_txe_d;  is_tx_q <= is_tx_d;  is_txe_q <= is_txe_d;
      in_tok_q <= in_tok_d;  j_q <= j_d;  t_q <= t_d;
      id_st_q <= id_st_d;  id_v_q <= id_v_d;  id_sat_q <= id_sat_d;
      id_neg_q <= id_neg_d;  id_have_q <= id_have_d;
      len_v_q <= len_v_d;  len_q <= len_d;  len_neg_q <= len_neg_d;
      len_stop_q <= len_stop_d;  len_have_q <= len_have_d;
      b_hi_q <= b_hi_d;  b_lo_q <= b_lo_d;  bi_q <= bi_d;  b_ok_q <= b_ok_d;  bad_q <= bad_d;
      data_q <= data_d;
      ov_q <= ov_d;  kind_q <= kind_d;  err_q <= err_d;  fid_q <= fid_d;
      ext_q <= ext_d;  flen_q <= flen_d;  pay_q <= pay_d;
    end
  end

  assign empty_o      = ~ov_q;
  assign kind_o       = kind_q;
  assign error_code_o = err_q;
  assign frame_id_o   = fid_q;
  assign extended_o   = ext_q;
  assign length_o     = flen_q;
  assign payload_o    = pay_q;

endmodule

// ===== hw/rtl/ascii_can_command_parser_core.sv =====
// Top level of the ASCII CAN command parser.
// Depends on accp_pkg, accp_front, accp_jobq and accp_back.
//
//  channel   handshake            ports
//  --------  -------------------  ------------------------------------------------
//  input     push / full          char_in_i
//  result    pop / empty          kind_o error_code_o frame_id_o extended_o
//                                 length_o payload_o
//
// An ordinary character is taken every cycle while full is low and written
// to the line store. A newline queues a job; the decoder takes it when idle,
// runs a trim pass over the whole line and a parse pass over the trimmed span
// through the store's single registered read port, then loads the result
// register once that register is empty.
// full is high from a newline until the parse pass (blank line: trim pass) ends.
// Reset empties the line and the result register; the store is not cleared.
// A waiting result stalls the next decode, and character input at the next newline.
module ascii_can_command_parser_core
  import accp_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  char_in_i,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] frame_id_o,
  output logic        extended_o,
  output logic [3:0]  length_o,
  output logic [63:0] payload_o
);

  wr_t  wr;
  job_t job_in, job_out;
  logic job_push, jq_full, jq_valid, job_pop, release_line;

  // front: line assembly, carriage return drop, overflow detection
  accp_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_in_i  (char_in_i),
    .push_i     (push),
    .full_o     (full),
    .wr_o       (wr),
    .job_push_o (job_push),
    .job_o      (job_in),
    .jq_full_i  (jq_full),
    .release_i  (release_line)
  );

  // decouples the front from a back end stalled on the result register
  accp_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (jq_full),
    .pop_i   (job_pop),
    .valid_o (jq_valid),
    .job_o   (job_out)
  );

  // back: line store, trim and parse passes, result register
  accp_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .job_valid_i  (jq_valid),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .release_o    (release_line),
    .empty_o      (empty),
    .pop_i        (pop),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .frame_id_o   (frame_id_o),
    .extended_o   (extended_o),
    .length_o     (length_o),
    .payload_o    (payload_o)
  );

endmodule
